// ===== rtl/core/i2chs_pkg.sv =====
package i2chs_pkg;

   localparam int COUNTER_WIDTH = 16;

   localparam int KIND_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 16;
   localparam int ADDR_W      = 7;
   localparam int BUSY_W      = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int BUF_DEPTH   = 6;
   localparam int POS_W       = 3;

   localparam int REQ_DATA_W  = BYTE_W + 2 * CODE_W;
   localparam int RSP_DATA_W  = 2 * BYTE_W + 3 * COUNTER_WIDTH;
   localparam int RSP_DATA_PW = ((RSP_DATA_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 3'd0,
      KIND_START = 3'd1,
      KIND_WRITE = 3'd2,
      KIND_READ  = 3'd3,
      KIND_STOP  = 3'd4
   } kind_type;

   typedef enum logic {
      RESP_ACK  = 1'b0,
      RESP_DATA = 1'b1
   } resp_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEV_ADDR       = 2'd0,
      CSR_DEVICE_PRESENT = 2'd1,
      CSR_BUSY_TICKS     = 2'd2
   } csr_index_type;

   localparam logic [CODE_W-1:0] CMD_MEAS_HIGH_STRETCH = 16'h2C06;
   localparam logic [CODE_W-1:0] CMD_MEAS_MED_STRETCH  = 16'h2C0D;
   localparam logic [CODE_W-1:0] CMD_MEAS_LOW_STRETCH  = 16'h2C10;
   localparam logic [CODE_W-1:0] CMD_MEAS_HIGH         = 16'h2400;
   localparam logic [CODE_W-1:0] CMD_MEAS_MED          = 16'h240B;
   localparam logic [CODE_W-1:0] CMD_MEAS_LOW          = 16'h2416;
   localparam logic [CODE_W-1:0] CMD_SOFT_RESET        = 16'h30A2;
   localparam logic [CODE_W-1:0] CMD_CLEAR_STATUS      = 16'h3041;
   localparam logic [CODE_W-1:0] CMD_READ_STATUS       = 16'hF32D;

   localparam logic [ADDR_W-1:0] DEV_ADDR_RESET   = 7'd68;
   localparam logic [BUSY_W-1:0] BUSY_TICKS_RESET = 20'd15000;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc_in ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] crc8_word(input logic [CODE_W-1:0] w);
      return crc8_byte(crc8_byte(CRC_INIT, w[CODE_W-1:BYTE_W]), w[BYTE_W-1:0]);
   endfunction

endpackage

// ===== rtl/core/i2c_humidity_sensor_slave.sv =====
// Transaction-level bus slave of a temperature and humidity sensor.
// Each request item is one bus event, chosen by req_tuser: tick, start with
// address byte, data write, data read or stop. Start, write and read events
// that address this device produce one response item on the rsp_ channel:
// an acknowledge, or a data byte for a read. Other events produce none.
// A two-byte command collected after a write address runs on the next stop
// or start; measure commands latch the temperature and humidity codes of
// that item with their CRC bytes and start the busy count, which tick items
// count down. A read address while busy is refused and counted.
// Each item is decoded in the cycle it is accepted and its response is held
// in the output register, so the response appears in the cycle after the
// request is accepted. One item is accepted every cycle while the response
// register is empty or being taken; when the receiver stalls with a response
// pending, req_tready drops until that response is taken. The csr_ port
// writes the address, presence and busy time registers; the user must use
// it only while no item is in flight; the block does not enforce this.
// Synchronous reset clears the bus state, counters and response register and
// loads register defaults; the buffer is undefined until a command fills it.
module i2c_humidity_sensor_slave (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bus_byte, temp_code, hum_code
   input  logic [i2chs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind
   input  logic [i2chs_pkg::KIND_W-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // resp_addr, resp_data, unknown_count, busy_nack_count, measure_count
   output logic [i2chs_pkg::RSP_DATA_PW-1:0]    rsp_tdata,
   // resp_kind
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [i2chs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2chs_pkg::BUSY_W-1:0]         csr_wdata
);

   localparam int CW = i2chs_pkg::COUNTER_WIDTH;
   localparam int BW = i2chs_pkg::BYTE_W;
   localparam int WC = i2chs_pkg::CODE_W;
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

   logic [i2chs_pkg::ADDR_W-1:0] dev_addr_ff;
   logic                         present_ff;
   logic [i2chs_pkg::BUSY_W-1:0] busy_ticks_ff;

   logic                         sel_valid_ff, sel_valid_in;
   logic [BW-1:0]                sel_addr_ff, sel_addr_in;
   logic [1:0]                   byte_count_ff, byte_count_in;
   logic [WC-1:0]                cmd_word_ff, cmd_word_in;
   logic [BW-1:0]                buf_ff [i2chs_pkg::BUF_DEPTH];
   logic [BW-1:0]                buf_in [i2chs_pkg::BUF_DEPTH];
   logic [i2chs_pkg::POS_W-1:0]  out_len_ff, out_len_in;
   logic [i2chs_pkg::POS_W-1:0]  out_pos_ff, out_pos_in;
   logic                         measuring_ff, measuring_in;
   logic [i2chs_pkg::BUSY_W-1:0] busy_left_ff, busy_left_in;
   logic [CW-1:0]                unknown_ff, unknown_in;
   logic [CW-1:0]                nack_ff, nack_in;
   logic [CW-1:0]                measure_ff, measure_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [BW-1:0]                rsp_addr_ff, rsp_addr_in;
   logic [BW-1:0]                rsp_byte_ff, rsp_byte_in;
   logic [CW-1:0]                rsp_unk_ff, rsp_nack_ff, rsp_meas_ff;

   logic                         accept;
   logic [BW-1:0]                bus_byte;
   logic [WC-1:0]                temp_code;
   logic [WC-1:0]                hum_code;
   logic                         cmd_run;

   assign bus_byte  = req_tdata[BW-1:0];
   assign temp_code = req_tdata[BW+WC-1:BW];
   assign hum_code  = req_tdata[BW+2*WC-1:BW+WC];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd_run    = sel_valid_ff && !sel_addr_ff[0] && (byte_count_ff >= 2'd2);

   always_comb begin
      sel_valid_in  = sel_valid_ff;
      sel_addr_in   = sel_addr_ff;
      byte_count_in = byte_count_ff;
      cmd_word_in   = cmd_word_ff;
      buf_in        = buf_ff;
      out_len_in    = out_len_ff;
      out_pos_in    = out_pos_ff;
      measuring_in  = measuring_ff;
      busy_left_in  = busy_left_ff;
      unknown_in    = unknown_ff;
      nack_in       = nack_ff;
      measure_in    = measure_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = i2chs_pkg::RESP_ACK;
      rsp_addr_in   = sel_addr_ff;
      rsp_byte_in   = '0;

      case (req_tuser)
         i2chs_pkg::KIND_TICK: begin
            if (busy_left_ff != '0) begin
               busy_left_in = busy_left_ff - 1'b1;
            end
         end
         i2chs_pkg::KIND_START, i2chs_pkg::KIND_STOP: begin
            if (cmd_run) begin
               case (cmd_word_ff) inside
                  i2chs_pkg::CMD_MEAS_HIGH, i2chs_pkg::CMD_MEAS_MED,
                  i2chs_pkg::CMD_MEAS_LOW, i2chs_pkg::CMD_MEAS_HIGH_STRETCH,
                  i2chs_pkg::CMD_MEAS_MED_STRETCH, i2chs_pkg::CMD_MEAS_LOW_STRETCH: begin
                     buf_in[0]    = temp_code[WC-1:BW];
                     buf_in[1]    = temp_code[BW-1:0];
                     buf_in[2]    = i2chs_pkg::crc8_word(temp_code);
                     buf_in[3]    = hum_code[WC-1:BW];
                     buf_in[4]    = hum_code[BW-1:0];
                     buf_in[5]    = i2chs_pkg::crc8_word(hum_code);
                     out_len_in   = 3'd6;
                     out_pos_in   = '0;
                     measuring_in = 1'b1;
                     busy_left_in = busy_ticks_ff;
                     if (measure_ff != CNT_MAX) begin
                        measure_in = measure_ff + 1'b1;
                     end
                  end
                  i2chs_pkg::CMD_SOFT_RESET, i2chs_pkg::CMD_CLEAR_STATUS: begin
                     out_len_in   = '0;
                     out_pos_in   = '0;
                     measuring_in = 1'b0;
                  end
                  i2chs_pkg::CMD_READ_STATUS: begin
                     buf_in[0]    = '0;
                     buf_in[1]    = '0;
                     buf_in[2]    = i2chs_pkg::crc8_word('0);
                     out_len_in   = 3'd3;
                     out_pos_in   = '0;
                     measuring_in = 1'b0;
                  end
                  default: begin
                     if (unknown_ff != CNT_MAX) begin
                        unknown_in = unknown_ff + 1'b1;
                     end
                  end
               endcase
            end
            sel_valid_in  = 1'b0;
            sel_addr_in   = '0;
            byte_count_in = '0;
            if (req_tuser == i2chs_pkg::KIND_START && present_ff
                && bus_byte[BW-1:1] == dev_addr_ff) begin
               if (bus_byte[0] && measuring_in && busy_left_in != '0) begin
                  if (nack_ff != CNT_MAX) begin
                     nack_in = nack_ff + 1'b1;
                  end
               end else begin
                  sel_valid_in = 1'b1;
                  sel_addr_in  = bus_byte;
                  rsp_valid_in = 1'b1;
                  rsp_addr_in  = bus_byte;
               end
            end
         end
         i2chs_pkg::KIND_WRITE: begin
            if (sel_valid_ff) begin
               if (byte_count_ff == 2'd0) begin
                  cmd_word_in = {bus_byte, {BW{1'b0}}};
               end else if (byte_count_ff == 2'd1) begin
                  cmd_word_in = {cmd_word_ff[WC-1:BW], bus_byte};
               end
               if (byte_count_ff != 2'd3) begin
                  byte_count_in = byte_count_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
            end
         end
         i2chs_pkg::KIND_READ: begin
            if (sel_valid_ff) begin
               rsp_byte_in = i2chs_pkg::FILL_BYTE;
               if (out_pos_ff < out_len_ff) begin
                  rsp_byte_in = buf_ff[out_pos_ff];
                  out_pos_in  = out_pos_ff + 1'b1;
               end
               if (out_pos_in >= out_len_ff) begin
                  measuring_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = i2chs_pkg::RESP_DATA;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= i2chs_pkg::DEV_ADDR_RESET;
         present_ff    <= 1'b1;
         busy_ticks_ff <= i2chs_pkg::BUSY_TICKS_RESET;
         sel_valid_ff  <= 1'b0;
         sel_addr_ff   <= '0;
         byte_count_ff <= '0;
         cmd_word_ff   <= '0;
         out_len_ff    <= '0;
         out_pos_ff    <= '0;
         measuring_ff  <= 1'b0;
         busy_left_ff  <= '0;
         unknown_ff    <= '0;
         nack_ff       <= '0;
         measure_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               i2chs_pkg::CSR_DEV_ADDR:       dev_addr_ff <= csr_wdata[i2chs_pkg::ADDR_W-1:0];
               i2chs_pkg::CSR_DEVICE_PRESENT: present_ff <= csr_wdata[0];
               i2chs_pkg::CSR_BUSY_TICKS:     busy_ticks_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            sel_valid_ff  <= sel_valid_in;
            sel_addr_ff   <= sel_addr_in;
            byte_count_ff <= byte_count_in;
            cmd_word_ff   <= cmd_word_in;
            out_len_ff    <= out_len_in;
            out_pos_ff    <= out_pos_in;
            measuring_ff  <= measuring_in;
            busy_left_ff  <= busy_left_in;
            unknown_ff    <= unknown_in;
            nack_ff       <= nack_in;
            measure_ff    <= measure_in;
            rsp_valid_ff  <= rsp_valid_in;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (accept) begin
         buf_ff      <= buf_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_unk_ff  <= unknown_in;
         rsp_nack_ff <= nack_in;
         rsp_meas_ff <= measure_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = i2chs_pkg::RSP_DATA_PW'({rsp_meas_ff, rsp_nack_ff, rsp_unk_ff,
                                                rsp_byte_ff, rsp_addr_ff});

endmodule
